[src/tbg_pkg.sv]
// Shared types, codes, character decode and 5x5 font table for the text banner renderer.
package tbg_pkg;

    localparam int FRAME_BYTES_DEF = 25;
    localparam int GLYPH_ROWS      = 5;
    localparam int GLYPH_COUNT     = 67;

    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_TIMEOUT = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_GLYPH = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;
    localparam logic [1:0] KIND_DROP  = 2'd3;

    localparam logic [6:0] NO_GLYPH = 7'(GLYPH_COUNT);

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] pixels;
        logic [2:0] row;
        logic [4:0] position;
        logic       row_end;
        logic       frame_end;
    } rsp_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] row;
        logic [4:0] position;
        logic       row_end;
        logic       frame_end;
    } seg_t;

    function automatic logic [6:0] glyph_of(input logic [7:0] b);
        logic [6:0] code;
        code = NO_GLYPH;
        if (b >= 8'h41 && b <= 8'h5A) code = 7'(b - 8'h41);
        else if (b >= 8'h61 && b <= 8'h7A) code = 7'(b - 8'h61) + 7'd26;
        else if (b >= 8'h30 && b <= 8'h39) code = 7'(b - 8'h30) + 7'd52;
        else if (b == 8'h20) code = 7'd62;
        else if (b == 8'h21) code = 7'd63;
        else if (b == 8'h2E) code = 7'd64;
        else if (b == 8'h2B) code = 7'd65;
        else if (b == 8'h2D) code = 7'd66;
        return code;
    endfunction

    // rows packed top row first
    function automatic logic [24:0] font_word(input logic [6:0] code);
        logic [24:0] w;
        case (code)
            7'd0:  w = {5'h0E, 5'h11, 5'h1F, 5'h11, 5'h11};
            7'd1:  w = {5'h1E, 5'h11, 5'h1E, 5'h11, 5'h1E};
            7'd2:  w = {5'h0F, 5'h10, 5'h10, 5'h10, 5'h0F};
            7'd3:  w = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E};
            7'd4:  w = {5'h1F, 5'h10, 5'h1C, 5'h10, 5'h1F};
            7'd5:  w = {5'h1F, 5'h10, 5'h1C, 5'h10, 5'h10};
            7'd6:  w = {5'h0F, 5'h10, 5'h13, 5'h11, 5'h0F};
            7'd7:  w = {5'h11, 5'h11, 5'h1F, 5'h11, 5'h11};
            7'd8:  w = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h0E};
            7'd9:  w = {5'h07, 5'h01, 5'h01, 5'h11, 5'h0E};
            7'd10: w = {5'h11, 5'h12, 5'h1C, 5'h12, 5'h11};
            7'd11: w = {5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            7'd12: w = {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11};
            7'd13: w = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11};
            7'd14: w = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
            7'd15: w = {5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10};
            7'd16: w = {5'h0E, 5'h11, 5'h11, 5'h13, 5'h0F};
            7'd17: w = {5'h1E, 5'h11, 5'h1E, 5'h12, 5'h11};
            7'd18: w = {5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E};
            7'd19: w = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04};
            7'd20: w = {5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            7'd21: w = {5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
            7'd22: w = {5'h11, 5'h11, 5'h15, 5'h1B, 5'h11};
            7'd23: w = {5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11};
            7'd24: w = {5'h11, 5'h0A, 5'h04, 5'h04, 5'h04};
            7'd25: w = {5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F};
            7'd26: w = {5'h00, 5'h0E, 5'h12, 5'h16, 5'h0D};
            7'd27: w = {5'h10, 5'h10, 5'h1E, 5'h11, 5'h1E};
            7'd28: w = {5'h00, 5'h0E, 5'h10, 5'h10, 5'h0E};
            7'd29: w = {5'h01, 5'h01, 5'h0F, 5'h11, 5'h0F};
            7'd30: w = {5'h00, 5'h0E, 5'h1F, 5'h10, 5'h0E};
            7'd31: w = {5'h06, 5'h08, 5'h1C, 5'h08, 5'h08};
            7'd32: w = {5'h00, 5'h0F, 5'h11, 5'h0F, 5'h0E};
            7'd33: w = {5'h10, 5'h10, 5'h1E, 5'h11, 5'h11};
            7'd34: w = {5'h04, 5'h00, 5'h0C, 5'h04, 5'h0E};
            7'd35: w = {5'h02, 5'h00, 5'h02, 5'h02, 5'h0C};
            7'd36: w = {5'h10, 5'h12, 5'h1C, 5'h12, 5'h11};
            7'd37: w = {5'h0C, 5'h04, 5'h04, 5'h04, 5'h0E};
            7'd38: w = {5'h00, 5'h1A, 5'h15, 5'h11, 5'h11};
            7'd39: w = {5'h00, 5'h1E, 5'h11, 5'h11, 5'h11};
            7'd40: w = {5'h00, 5'h0E, 5'h11, 5'h11, 5'h0E};
            7'd41: w = {5'h00, 5'h1E, 5'h11, 5'h1E, 5'h10};
            7'd42: w = {5'h00, 5'h0F, 5'h11, 5'h0F, 5'h01};
            7'd43: w = {5'h00, 5'h0E, 5'h10, 5'h10, 5'h10};
            7'd44: w = {5'h00, 5'h0E, 5'h0C, 5'h06, 5'h0E};
            7'd45: w = {5'h08, 5'h1C, 5'h08, 5'h08, 5'h06};
            7'd46: w = {5'h00, 5'h11, 5'h11, 5'h11, 5'h0F};
            7'd47: w = {5'h00, 5'h11, 5'h11, 5'h0A, 5'h04};
            7'd48: w = {5'h00, 5'h11, 5'h15, 5'h15, 5'h0A};
            7'd49: w = {5'h00, 5'h11, 5'h0A, 5'h0A, 5'h11};
            7'd50: w = {5'h00, 5'h11, 5'h11, 5'h0F, 5'h01};
            7'd51: w = {5'h00, 5'h1F, 5'h04, 5'h08, 5'h1F};
            7'd52: w = {5'h0E, 5'h13, 5'h15, 5'h19, 5'h0E};
            7'd53: w = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h0E};
            7'd54: w = {5'h0E, 5'h11, 5'h06, 5'h08, 5'h1F};
            7'd55: w = {5'h0E, 5'h01, 5'h06, 5'h01, 5'h0E};
            7'd56: w = {5'h12, 5'h12, 5'h1F, 5'h02, 5'h02};
            7'd57: w = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h1E};
            7'd58: w = {5'h0E, 5'h10, 5'h1E, 5'h11, 5'h0E};
            7'd59: w = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h04};
            7'd60: w = {5'h0E, 5'h11, 5'h0E, 5'h11, 5'h0E};
            7'd61: w = {5'h0E, 5'h11, 5'h0F, 5'h01, 5'h0E};
            7'd62: w = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
            7'd63: w = {5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
            7'd64: w = {5'h00, 5'h00, 5'h00, 5'h00, 5'h04};
            7'd65: w = {5'h00, 5'h04, 5'h1F, 5'h04, 5'h00};
            7'd66: w = {5'h00, 5'h00, 5'h1F, 5'h00, 5'h00};
            default: w = 25'h0;
        endcase
        return w;
    endfunction

    function automatic logic [4:0] font_row(input logic [6:0] code, input logic [2:0] row);
        logic [24:0] w;
        logic [4:0]  r;
        w = font_word(code);
        case (row)
            3'd0:    r = w[24:20];
            3'd1:    r = w[19:15];
            3'd2:    r = w[14:10];
            3'd3:    r = w[9:5];
            3'd4:    r = w[4:0];
            default: r = 5'h0;
        endcase
        return r;
    endfunction

endpackage

[src/tbg_glyph_mem.sv]
// Glyph code store: one write port, one registered read port.
module tbg_glyph_mem
    import tbg_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [6:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [6:0]    rd_data
);

    logic [6:0] mem [FRAME_BYTES];
    logic [6:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/tbg_seq.sv]
// Frame sequencer: collects bytes, tracks the scan position and issues store accesses.
module tbg_seq
    import tbg_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1,
    parameter int CW = $clog2(FRAME_BYTES + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  req_t          req,
    output seg_t          seg,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [6:0]    wr_data,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr
);

    localparam logic [CW-1:0] FB_C     = CW'(FRAME_BYTES);
    localparam logic [2:0]    LAST_ROW = 3'(GLYPH_ROWS - 1);

    logic [CW-1:0] glyph_total_reg, glyph_total_next;
    logic [CW-1:0] byte_total_reg, byte_total_next;
    logic          showing_reg, showing_next;
    logic [2:0]    scan_row_reg, scan_row_next;
    logic [AW-1:0] scan_pos_reg, scan_pos_next;

    logic [6:0]    code;
    logic          last_row;
    logic          row_done;
    logic [AW+4:0] pos_wide;

    always_comb
    begin
        code             = glyph_of(req.rx_byte);
        last_row         = (scan_row_reg == LAST_ROW);
        row_done         = ((CW+1)'(scan_pos_reg) + (CW+1)'(1)) >= (CW+1)'(glyph_total_reg);
        pos_wide         = {5'b0, scan_pos_reg};

        glyph_total_next = glyph_total_reg;
        byte_total_next  = byte_total_reg;
        showing_next     = showing_reg;
        scan_row_next    = scan_row_reg;
        scan_pos_next    = scan_pos_reg;

        seg              = '0;
        seg.kind         = KIND_NONE;
        wr_en            = 1'b0;
        wr_addr          = glyph_total_reg[AW-1:0];
        wr_data          = code;
        rd_en            = 1'b0;
        rd_addr          = scan_pos_reg;

        if (take)
        begin
            case (req.opcode)
                OP_BYTE:
                begin
                    if (showing_reg)
                    begin
                        seg.kind = KIND_DROP;
                    end
                    else
                    begin
                        if (code != NO_GLYPH && glyph_total_reg < FB_C)
                        begin
                            wr_en            = 1'b1;
                            glyph_total_next = glyph_total_reg + CW'(1);
                        end
                        byte_total_next = byte_total_reg + CW'(1);
                        if (byte_total_next == FB_C)
                        begin
                            showing_next  = 1'b1;
                            scan_row_next = 3'd0;
                            scan_pos_next = '0;
                        end
                    end
                end
                OP_TIMEOUT:
                begin
                    if (!showing_reg && byte_total_reg != '0)
                    begin
                        showing_next  = 1'b1;
                        scan_row_next = 3'd0;
                        scan_pos_next = '0;
                    end
                end
                OP_ADVANCE:
                begin
                    if (showing_reg)
                    begin
                        seg.row = scan_row_reg;
                        if (glyph_total_reg == '0)
                        begin
                            seg.kind      = KIND_EMPTY;
                            seg.row_end   = 1'b1;
                            seg.frame_end = last_row;
                            scan_row_next = scan_row_reg + 3'd1;
                        end
                        else
                        begin
                            seg.kind     = KIND_GLYPH;
                            seg.position = pos_wide[4:0];
                            rd_en        = 1'b1;
                            if (row_done)
                            begin
                                seg.row_end   = 1'b1;
                                seg.frame_end = last_row;
                                scan_pos_next = '0;
                                scan_row_next = scan_row_reg + 3'd1;
                            end
                            else
                            begin
                                scan_pos_next = scan_pos_reg + AW'(1);
                            end
                        end
                        if (seg.frame_end)
                        begin
                            glyph_total_next = '0;
                            byte_total_next  = '0;
                            showing_next     = 1'b0;
                            scan_row_next    = 3'd0;
                            scan_pos_next    = '0;
                        end
                    end
                end
                default:
                begin
                    seg.kind = KIND_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_total_reg <= '0;
            byte_total_reg  <= '0;
            showing_reg     <= 1'b0;
            scan_row_reg    <= 3'd0;
            scan_pos_reg    <= '0;
        end
        else
        begin
            glyph_total_reg <= glyph_total_next;
            byte_total_reg  <= byte_total_next;
            showing_reg     <= showing_next;
            scan_row_reg    <= scan_row_next;
            scan_pos_reg    <= scan_pos_next;
        end
    end

endmodule

[src/tbg_render.sv]
// Segment stage and output register: font row lookup and downstream handshake.
module tbg_render
    import tbg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  seg_t       seg,
    input  logic [6:0] rd_data,
    output logic       hold,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output rsp_t       rsp
);

    logic s1_valid_reg, s1_valid_next;
    seg_t s1_reg;
    logic out_valid_reg, out_valid_next;
    rsp_t out_reg;
    logic s1_adv;
    rsp_t out_next;

    always_comb
    begin
        s1_adv         = s1_valid_reg && (!out_valid_reg || !rsp_stall);
        hold           = s1_valid_reg && !s1_adv;
        s1_valid_next  = take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (out_valid_reg && rsp_stall);

        out_next.kind      = s1_reg.kind;
        out_next.pixels    = (s1_reg.kind == KIND_GLYPH) ? font_row(rd_data, s1_reg.row) : 5'h0;
        out_next.row       = s1_reg.row;
        out_next.position  = s1_reg.position;
        out_next.row_end   = s1_reg.row_end;
        out_next.frame_end = s1_reg.frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_reg <= seg;
        end
        if (s1_adv)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

[src/text_banner_glyph_renderer_unit.sv]
// Top level of the text banner glyph renderer: sequencer, glyph store and output stage.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid, req_stall | req_t  (opcode, rx_byte)
//  rsp     | out       | rsp_valid, rsp_stall | rsp_t  (kind, pixels, row, position, ...)
//
// One request per cycle is taken unless req_stall; each gives exactly one response.
// The glyph store read is issued at the request transfer; the font lookup follows
// from the registered read data into the output register.
// Reset clears the counters and pipeline valids at once; the store needs no sweep.
// req_stall rises only when the output register is full and stalled with a second
// response waiting behind it.
module text_banner_glyph_renderer_unit
    import tbg_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int CW = $clog2(FRAME_BYTES + 1);

    logic          take;
    logic          hold;
    seg_t          seg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [6:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [6:0]    rd_data;

    assign req_stall = hold;
    assign take      = req_valid && !hold;

    tbg_seq #(
        .FRAME_BYTES(FRAME_BYTES),
        .AW(AW),
        .CW(CW)
    ) u_seq (
        .clk(clk),
        .rst_n(rst_n),
        .take(take),
        .req(req),
        .seg(seg),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en(rd_en),
        .rd_addr(rd_addr)
    );

    tbg_glyph_mem #(
        .FRAME_BYTES(FRAME_BYTES),
        .AW(AW)
    ) u_mem (
        .clk(clk),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    tbg_render u_render (
        .clk(clk),
        .rst_n(rst_n),
        .take(take),
        .seg(seg),
        .rd_data(rd_data),
        .hold(hold),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall))
        else $error("request stalled while output register can drain");

    a_frame_end_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.frame_end) |-> (rsp.row_end && rsp.row == 3'(GLYPH_ROWS - 1)))
        else $error("frame end outside the last row");

    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.kind == KIND_NONE || rsp.kind == KIND_DROP))
        |-> (rsp.pixels == 5'h0 && rsp.row == 3'd0 && rsp.position == 5'h0
             && !rsp.row_end && !rsp.frame_end))
        else $error("non-segment response carries segment fields");

    a_empty_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.kind == KIND_EMPTY)
        |-> (rsp.pixels == 5'h0 && rsp.position == 5'h0 && rsp.row_end))
        else $error("malformed empty row mark");

endmodule

[dv/tb.sv]
// Self-checking testbench for the text banner glyph renderer: frames, scan-out and busy drops.
module tb
    import tbg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_RESERVED  = 2'd3;
    localparam int         FONT_SIZE    = 67;
    localparam int         RANDOM_ITEMS = 1750;
    localparam int         LONG_HOLD    = 200;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         CYCLE_LIMIT  = 600000;

    localparam logic [4:0] FONT_ROWS [FONT_SIZE][5] = '{
        '{5'h0E, 5'h11, 5'h1F, 5'h11, 5'h11}, '{5'h1E, 5'h11, 5'h1E, 5'h11, 5'h1E},
        '{5'h0F, 5'h10, 5'h10, 5'h10, 5'h0F}, '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E},
        '{5'h1F, 5'h10, 5'h1C, 5'h10, 5'h1F}, '{5'h1F, 5'h10, 5'h1C, 5'h10, 5'h10},
        '{5'h0F, 5'h10, 5'h13, 5'h11, 5'h0F}, '{5'h11, 5'h11, 5'h1F, 5'h11, 5'h11},
        '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h0E}, '{5'h07, 5'h01, 5'h01, 5'h11, 5'h0E},
        '{5'h11, 5'h12, 5'h1C, 5'h12, 5'h11}, '{5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
        '{5'h11, 5'h1B, 5'h15, 5'h11, 5'h11}, '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E}, '{5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10},
        '{5'h0E, 5'h11, 5'h11, 5'h13, 5'h0F}, '{5'h1E, 5'h11, 5'h1E, 5'h12, 5'h11},
        '{5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E}, '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}, '{5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
        '{5'h11, 5'h11, 5'h15, 5'h1B, 5'h11}, '{5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11},
        '{5'h11, 5'h0A, 5'h04, 5'h04, 5'h04}, '{5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F},
        '{5'h00, 5'h0E, 5'h12, 5'h16, 5'h0D}, '{5'h10, 5'h10, 5'h1E, 5'h11, 5'h1E},
        '{5'h00, 5'h0E, 5'h10, 5'h10, 5'h0E}, '{5'h01, 5'h01, 5'h0F, 5'h11, 5'h0F},
        '{5'h00, 5'h0E, 5'h1F, 5'h10, 5'h0E}, '{5'h06, 5'h08, 5'h1C, 5'h08, 5'h08},
        '{5'h00, 5'h0F, 5'h11, 5'h0F, 5'h0E}, '{5'h10, 5'h10, 5'h1E, 5'h11, 5'h11},
        '{5'h04, 5'h00, 5'h0C, 5'h04, 5'h0E}, '{5'h02, 5'h00, 5'h02, 5'h02, 5'h0C},
        '{5'h10, 5'h12, 5'h1C, 5'h12, 5'h11}, '{5'h0C, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h00, 5'h1A, 5'h15, 5'h11, 5'h11}, '{5'h00, 5'h1E, 5'h11, 5'h11, 5'h11},
        '{5'h00, 5'h0E, 5'h11, 5'h11, 5'h0E}, '{5'h00, 5'h1E, 5'h11, 5'h1E, 5'h10},
        '{5'h00, 5'h0F, 5'h11, 5'h0F, 5'h01}, '{5'h00, 5'h0E, 5'h10, 5'h10, 5'h10},
        '{5'h00, 5'h0E, 5'h0C, 5'h06, 5'h0E}, '{5'h08, 5'h1C, 5'h08, 5'h08, 5'h06},
        '{5'h00, 5'h11, 5'h11, 5'h11, 5'h0F}, '{5'h00, 5'h11, 5'h11, 5'h0A, 5'h04},
        '{5'h00, 5'h11, 5'h15, 5'h15, 5'h0A}, '{5'h00, 5'h11, 5'h0A, 5'h0A, 5'h11},
        '{5'h00, 5'h11, 5'h11, 5'h0F, 5'h01}, '{5'h00, 5'h1F, 5'h04, 5'h08, 5'h1F},
        '{5'h0E, 5'h13, 5'h15, 5'h19, 5'h0E}, '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h11, 5'h06, 5'h08, 5'h1F}, '{5'h0E, 5'h01, 5'h06, 5'h01, 5'h0E},
        '{5'h12, 5'h12, 5'h1F, 5'h02, 5'h02}, '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h1E},
        '{5'h0E, 5'h10, 5'h1E, 5'h11, 5'h0E}, '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h04},
        '{5'h0E, 5'h11, 5'h0E, 5'h11, 5'h0E}, '{5'h0E, 5'h11, 5'h0F, 5'h01, 5'h0E},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00}, '{5'h04, 5'h04, 5'h04, 5'h00, 5'h04},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h04}, '{5'h00, 5'h04, 5'h1F, 5'h04, 5'h00},
        '{5'h00, 5'h00, 5'h1F, 5'h00, 5'h00}
    };

    function automatic int unsigned char_to_glyph(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return c - "A";
        if (c >= "a" && c <= "z") return 26 + (c - "a");
        if (c >= "0" && c <= "9") return 52 + (c - "0");
        case (c)
            " ": return 62;
            "!": return 63;
            ".": return 64;
            "+": return 65;
            "-": return 66;
            default: return FONT_SIZE;
        endcase
    endfunction

    function automatic logic [7:0] glyph_to_char(input int unsigned g);
        if (g < 26) return 8'("A" + g);
        if (g < 52) return 8'("a" + (g - 26));
        if (g < 62) return 8'("0" + (g - 52));
        case (g)
            62: return " ";
            63: return "!";
            64: return ".";
            65: return "+";
            default: return "-";
        endcase
    endfunction

    class banner_scoreboard;
        int unsigned glyph_mem [FRAME_BYTES_DEF];
        int unsigned glyph_cnt;
        int unsigned byte_cnt;
        bit          showing;
        int unsigned scan_row;
        int unsigned scan_col;
        rsp_t        segs_due [$];
        int          errors;

        function new();
            clear_frame();
            errors = 0;
        endfunction

        function void clear_frame();
            glyph_cnt = 0;
            byte_cnt  = 0;
            showing   = 1'b0;
            scan_row  = 0;
            scan_col  = 0;
        endfunction

        function int pending();
            return segs_due.size();
        endfunction

        // returns 1 when the transfer did more than get ignored
        function bit note_request(input req_t item);
            rsp_t        seg;
            int unsigned g;
            bit          last_row;
            bit          effect;
            seg    = '0;
            effect = 1'b0;
            case (item.opcode)
                OP_BYTE:
                begin
                    effect = 1'b1;
                    if (showing)
                        seg.kind = KIND_DROP;
                    else
                    begin
                        g = char_to_glyph(item.rx_byte);
                        if (g < FONT_SIZE && glyph_cnt < FRAME_BYTES_DEF)
                        begin
                            glyph_mem[glyph_cnt] = g;
                            glyph_cnt++;
                        end
                        byte_cnt++;
                        if (byte_cnt >= FRAME_BYTES_DEF)
                        begin
                            showing  = 1'b1;
                            scan_row = 0;
                            scan_col = 0;
                        end
                    end
                end
                OP_TIMEOUT:
                begin
                    if (!showing && byte_cnt > 0)
                    begin
                        effect   = 1'b1;
                        showing  = 1'b1;
                        scan_row = 0;
                        scan_col = 0;
                    end
                end
                OP_ADVANCE:
                begin
                    if (showing)
                    begin
                        effect   = 1'b1;
                        last_row = scan_row >= GLYPH_ROWS - 1;
                        seg.row  = 3'(scan_row);
                        if (glyph_cnt == 0)
                        begin
                            seg.kind      = KIND_EMPTY;
                            seg.row_end   = 1'b1;
                            seg.frame_end = last_row;
                            scan_row++;
                        end
                        else
                        begin
                            seg.kind     = KIND_GLYPH;
                            seg.pixels   = FONT_ROWS[glyph_mem[scan_col]][scan_row];
                            seg.position = 5'(scan_col);
                            if (scan_col + 1 >= glyph_cnt)
                            begin
                                seg.row_end   = 1'b1;
                                seg.frame_end = last_row;
                                scan_col      = 0;
                                scan_row++;
                            end
                            else
                                scan_col++;
                        end
                        if (seg.frame_end)
                            clear_frame();
                    end
                end
                default: ;
            endcase
            segs_due.push_back(seg);
            return effect;
        endfunction

        function void compare_field(input string tag, input logic [4:0] want,
                                    input logic [4:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, want, got);
            end
        endfunction

        function void check_response(input rsp_t got);
            rsp_t want;
            if (segs_due.size() == 0)
            begin
                errors++;
                $display("%0t: response with nothing pending, expected none, actual %p",
                         $time, got);
                return;
            end
            want = segs_due.pop_front();
            compare_field("kind", 5'(want.kind), 5'(got.kind));
            compare_field("pixels", want.pixels, got.pixels);
            compare_field("row", 5'(want.row), 5'(got.row));
            compare_field("position", want.position, got.position);
            compare_field("row_end", 5'(want.row_end), 5'(got.row_end));
            compare_field("frame_end", 5'(want.frame_end), 5'(got.frame_end));
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    banner_scoreboard sb;
    int unsigned      applied     = 0;
    int unsigned      taken       = 0;
    int unsigned      cycle_count = 0;
    bit               sender_calm = 1'b0;

    text_banner_glyph_renderer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(15, 50);
    endfunction

    task automatic send_req(input logic [1:0] op, input logic [7:0] b);
        req_t        item;
        int unsigned n;
        item.opcode  = op;
        item.rx_byte = b;
        req_valid <= 1'b1;
        req       <= item;
        @(negedge clk);
        while (req_stall)
            @(negedge clk);
        @(posedge clk);
        if (sb.note_request(item))
            applied++;
        if ($urandom_range(0, 99) == 0)
            sender_calm = !sender_calm;
        n = sender_calm ? 0 : idle_len();
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [7:0] frame_char(input bit no_glyphs);
        if (no_glyphs)
            return $urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(123, 255));
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return glyph_to_char($urandom_range(0, FONT_SIZE - 1));
    endfunction

    task automatic run_directed();
        send_req(OP_ADVANCE, 8'hFF);
        send_req(OP_RESERVED, 8'h00);
        send_req(OP_TIMEOUT, 8'h55);
        send_req(OP_BYTE, 8'h00);
        send_req(OP_BYTE, 8'hFF);
        send_req(OP_TIMEOUT, 8'hAA);
        send_req(OP_BYTE, "A");
        send_req(OP_TIMEOUT, 8'h00);
        send_req(OP_RESERVED, 8'hFF);
        repeat (GLYPH_ROWS) send_req(OP_ADVANCE, 8'($urandom_range(0, 255)));
        send_req(OP_BYTE, "Z");
        send_req(OP_BYTE, "@");
        send_req(OP_BYTE, "!");
        send_req(OP_TIMEOUT, 8'h7F);
        repeat (2 * GLYPH_ROWS) send_req(OP_ADVANCE, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_random();
        int unsigned want_len;
        bit          no_glyphs;
        bit          paused;
        int unsigned r;
        int unsigned target;
        want_len  = 0;
        no_glyphs = 1'b0;
        paused    = 1'b0;
        target    = applied + RANDOM_ITEMS;
        while (applied < target)
        begin
            if ($urandom_range(0, 99) < 7)
                send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            else if (sb.showing)
            begin
                want_len = 0;
                send_req(OP_ADVANCE, 8'($urandom_range(0, 255)));
            end
            else
            begin
                if (want_len == 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 60) want_len = $urandom_range(1, 4);
                    else if (r < 85) want_len = $urandom_range(5, 12);
                    else if (r < 92) want_len = $urandom_range(13, 24);
                    else want_len = FRAME_BYTES_DEF;
                    no_glyphs = $urandom_range(0, 9) == 0;
                end
                if (sb.byte_cnt >= want_len)
                begin
                    send_req(OP_TIMEOUT, 8'($urandom_range(0, 255)));
                    want_len = 0;
                end
                else
                    send_req(OP_BYTE, frame_char(no_glyphs));
            end
            if (!paused && applied >= target - RANDOM_ITEMS / 2)
            begin
                paused = 1'b1;
                req_valid <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        bit          calm;
        int unsigned n;
        int unsigned hold_at;
        calm    = 1'b0;
        hold_at = 300;
        forever
        begin
            @(posedge clk);
            if (rst_n && taken >= hold_at)
            begin
                hold_at = (hold_at < 1000) ? 1300 : 32'hFFFF_FFFF;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if ($urandom_range(0, 149) == 0)
                    calm = !calm;
                n = calm ? 0 : idle_len();
                if (n > 0)
                begin
                    rsp_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            rsp_stall <= 1'b0;
        end
    end

    initial
    begin
        rsp_t seen;
        forever
        begin
            @(negedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                seen = rsp;
                @(posedge clk);
                taken++;
                sb.check_response(seen);
            end
        end
    end

endmodule

[filelist.f]
src/tbg_pkg.sv
src/tbg_glyph_mem.sv
src/tbg_seq.sv
src/tbg_render.sv
src/text_banner_glyph_renderer_unit.sv
dv/tb.sv
